// ===== src/owd_pkg.sv =====
// Shared types, keyboard tables and cost functions for the weighted edit distance block.
package owd_pkg;

    localparam int LETTER_W = 5;
    localparam int COST_W   = 8;
    localparam int DIST_W   = 14;
    localparam int DIST_MAX = 16383;

    localparam logic OP_QUERY     = 1'b0;
    localparam logic OP_CANDIDATE = 1'b1;

    localparam logic [1:0] REG_EDIT       = 2'd0;
    localparam logic [1:0] REG_TRANSPOSE  = 2'd1;
    localparam logic [1:0] REG_NEIGHBOUR  = 2'd2;
    localparam logic [1:0] REG_SOUND_PAIR = 2'd3;

    typedef struct packed {
        logic                op;
        logic [LETTER_W-1:0] letter;
        logic                last;
    } owd_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              too_long;
    } owd_out_t;

    typedef struct packed {
        logic [COST_W-1:0] edit_cost;
        logic [COST_W-1:0] transpose_cost;
        logic [COST_W-1:0] neighbour_cost;
        logic [COST_W-1:0] sound_pair_cost;
    } owd_cfg_t;

    // Control that travels with one candidate letter down the cell row.
    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last;
        logic                score;
        logic                too_long;
        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] prev_letter;
    } owd_wave_t;

    // Query letter of a cell as seen by its right-hand neighbor.
    typedef struct packed {
        logic                present;
        logic [LETTER_W-1:0] letter;
    } owd_nb_t;

    localparam logic [5:0] KEY_POS [32] = '{
        6'd13, 6'd30, 6'd9,  6'd24, 6'd33, 6'd16, 6'd37, 6'd36,
        6'd18, 6'd0,  6'd12, 6'd29, 6'd14, 6'd20, 6'd25, 6'd17,
        6'd21, 6'd10, 6'd22, 6'd8,  6'd1,  6'd40, 6'd4,  6'd6,
        6'd28, 6'd32, 6'd44, 6'd5,  6'd26, 6'd41, 6'd34, 6'd2
    };

    localparam logic [1:0] KEY_ROW [32] = '{
        2'd1, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0,
        2'd2, 2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd1,
        2'd1, 2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd0, 2'd2,
        2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2
    };

    function automatic logic is_sound_pair(input logic [LETTER_W-1:0] a,
                                           input logic [LETTER_W-1:0] b);
        logic [LETTER_W-1:0] lo;
        logic [LETTER_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return {lo, hi} inside {
            {5'd0, 5'd14}, {5'd5, 5'd8},  {5'd8, 5'd9},
            {5'd7, 5'd17}, {5'd6, 5'd24}, {5'd1, 5'd15},
            {5'd2, 5'd20}, {5'd4, 5'd18}, {5'd3, 5'd10}
        };
    endfunction

    function automatic logic is_key_neighbour(input logic [LETTER_W-1:0] a,
                                              input logic [LETTER_W-1:0] b);
        logic [5:0] pos_diff;
        logic       row_far;
        pos_diff = (KEY_POS[a] > KEY_POS[b]) ? KEY_POS[a] - KEY_POS[b]
                                             : KEY_POS[b] - KEY_POS[a];
        row_far  = (KEY_ROW[a] == 2'd0 && KEY_ROW[b] == 2'd2) ||
                   (KEY_ROW[a] == 2'd2 && KEY_ROW[b] == 2'd0);
        return (pos_diff <= 6'd5) && !row_far;
    endfunction

    function automatic logic [COST_W-1:0] sub_cost(input logic [LETTER_W-1:0] a,
                                                   input logic [LETTER_W-1:0] b,
                                                   input owd_cfg_t         cfg);
        logic [COST_W-1:0] cost;
        if (a == b)
        begin
            cost = '0;
        end
        else if (is_sound_pair(a, b))
        begin
            cost = cfg.sound_pair_cost;
        end
        else if (is_key_neighbour(a, b))
        begin
            cost = cfg.neighbour_cost;
        end
        else
        begin
            cost = cfg.edit_cost;
        end
        return cost;
    endfunction

endpackage

// ===== src/owd_cell.sv =====
// One cell of the row: holds one query letter and one row of the score table.
module owd_cell #(
    parameter int COL_W = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  owd_pkg::owd_cfg_t             cfg,
    input  logic                          q_we,
    input  logic [owd_pkg::LETTER_W-1:0]  q_letter,
    input  owd_pkg::owd_nb_t              left_nb,
    input  owd_pkg::owd_wave_t            left_ctrl,
    input  logic [COL_W-1:0]              left_cur,
    input  logic [COL_W-1:0]              left_diag,
    input  logic [COL_W-1:0]              left_diag2,
    output owd_pkg::owd_nb_t              out_nb,
    output owd_pkg::owd_wave_t            out_ctrl,
    output logic [COL_W-1:0]              out_cur,
    output logic [COL_W-1:0]              out_diag,
    output logic [COL_W-1:0]              out_diag2
);
    import owd_pkg::*;

    logic [LETTER_W-1:0] q_reg;
    logic [COL_W-1:0]    d_reg;
    logic [COL_W-1:0]    d_next;
    logic [COL_W-1:0]    old_left_reg;
    logic [COL_W-1:0]    old_left_next;
    owd_wave_t           ctrl_reg;
    logic [COL_W-1:0]    cur_reg;
    logic [COL_W-1:0]    diag_reg;
    logic [COL_W-1:0]    diag2_reg;

    logic [COL_W-1:0] own_prev;
    logic [COL_W-1:0] del_sum;
    logic [COL_W-1:0] ins_sum;
    logic [COL_W-1:0] sub_sum;
    logic [COL_W-1:0] tr_sum;
    logic [COL_W-1:0] best;
    logic [COL_W-1:0] edit_ext;
    logic             tr_en;
    logic             upd;

    always_comb
    begin
        edit_ext = COL_W'(cfg.edit_cost);
        own_prev = left_ctrl.first ? left_diag + edit_ext : d_reg;
        del_sum  = own_prev + edit_ext;
        ins_sum  = left_cur + edit_ext;
        sub_sum  = left_diag + COL_W'(sub_cost(q_reg, left_ctrl.letter, cfg));
        tr_sum   = left_diag2 + COL_W'(cfg.transpose_cost);
        tr_en    = !left_ctrl.first && left_nb.present &&
                   (q_reg == left_ctrl.prev_letter) &&
                   (left_nb.letter == left_ctrl.letter);
        best     = (del_sum < ins_sum) ? del_sum : ins_sum;
        if (sub_sum < best)
        begin
            best = sub_sum;
        end
        if (tr_en && tr_sum < best)
        begin
            best = tr_sum;
        end
        upd           = left_ctrl.valid && left_ctrl.score;
        d_next        = upd ? best : d_reg;
        old_left_next = upd ? left_diag : old_left_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= left_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_reg <= q_letter;
        end
        d_reg        <= d_next;
        old_left_reg <= old_left_next;
        cur_reg      <= best;
        diag_reg     <= own_prev;
        diag2_reg    <= old_left_reg;
    end

    assign out_nb.present = 1'b1;
    assign out_nb.letter  = q_reg;
    assign out_ctrl       = ctrl_reg;
    assign out_cur        = cur_reg;
    assign out_diag       = diag_reg;
    assign out_diag2      = diag2_reg;

endmodule

// ===== src/weighted_osa_edit_distance.sv =====
// Top level of the weighted edit distance block: word intake, cell row and result tap.
//
// A word on item is taken at a clock edge with start high and busy low. Query
// letters (op = 0) load the cells one by one; a query letter after a closed
// query starts a new one. Candidate letters (op = 1) may follow one per cycle
// while busy is low: each launches a wave that moves one cell per cycle down a
// row of MAX_LETTERS cells, each cell holding one query letter and one row of
// the score table. A candidate letter with last set produces one result word.
// It appears on result with result_valid high for exactly one cycle, once the
// wave has left the cell of the last query letter and result_reg has taken
// the tap at cell output query_length, the stored query length (at most
// MAX_LETTERS). busy stays high from that final letter until result_valid
// rises, so no further word is taken while a result is pending. The receiver
// cannot stall; result keeps its word until the next result, but result_valid
// marks it for its one cycle only.
// Configuration writes on cfg_valid/cfg_ready are always ready and take effect
// at once; they are meant for idle periods. Reset clears the costs to 100, 70,
// 80 and 65, empties the query and drops any candidate; no clearing pass runs.
module weighted_osa_edit_distance #(
    parameter int MAX_LETTERS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  owd_pkg::owd_in_t  item,
    output logic              result_valid,
    output owd_pkg::owd_out_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [owd_pkg::COST_W-1:0] cfg_data
);
    import owd_pkg::*;

    localparam int COL_W = $clog2((2 * MAX_LETTERS + 1) * 255 + 1);
    localparam int QL_W  = $clog2(MAX_LETTERS + 1);
    localparam int EXT_W = (COL_W > DIST_W) ? COL_W : DIST_W;

    owd_cfg_t          cfg_reg;
    owd_cfg_t          cfg_next;
    logic [QL_W-1:0]   query_length_reg;
    logic [QL_W-1:0]   query_length_next;
    logic              query_done_reg;
    logic              query_done_next;
    logic              query_over_reg;
    logic              query_over_next;
    logic [QL_W-1:0]   cand_len_reg;
    logic [QL_W-1:0]   cand_len_next;
    logic              cand_over_reg;
    logic              cand_over_next;
    logic [LETTER_W-1:0] prev_letter_reg;
    logic [LETTER_W-1:0] prev_letter_next;
    logic [COL_W-1:0]  bound_reg;
    logic [COL_W-1:0]  bound_next;
    logic              drain_reg;
    logic              drain_next;
    owd_wave_t         h_ctrl_reg;
    owd_wave_t         h_ctrl_next;
    logic [COL_W-1:0]  h_cur_reg;
    logic [COL_W-1:0]  h_cur_next;
    logic [COL_W-1:0]  h_diag_reg;
    logic [COL_W-1:0]  h_diag_next;
    logic              result_valid_reg;
    owd_out_t          result_reg;

    logic              accept;
    logic [QL_W-1:0]   wr_idx;
    logic              q_we;
    logic              first;
    logic              score;
    logic              capture;
    logic [EXT_W-1:0]  long_dist;
    logic [EXT_W-1:0]  tap_dist;
    logic [EXT_W-1:0]  pick_dist;

    owd_wave_t        ctrl_s  [MAX_LETTERS+1];
    logic [COL_W-1:0] cur_s   [MAX_LETTERS+1];
    logic [COL_W-1:0] diag_s  [MAX_LETTERS+1];
    logic [COL_W-1:0] diag2_s [MAX_LETTERS+1];
    owd_nb_t          nb_s    [MAX_LETTERS+1];

    assign accept    = start && !busy;
    assign busy      = drain_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_EDIT:       cfg_next.edit_cost       = cfg_data;
                REG_TRANSPOSE:  cfg_next.transpose_cost  = cfg_data;
                REG_NEIGHBOUR:  cfg_next.neighbour_cost  = cfg_data;
                REG_SOUND_PAIR: cfg_next.sound_pair_cost = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        query_length_next = query_length_reg;
        query_done_next   = query_done_reg;
        query_over_next   = query_over_reg;
        cand_len_next     = cand_len_reg;
        cand_over_next    = cand_over_reg;
        prev_letter_next  = prev_letter_reg;
        bound_next        = bound_reg;
        drain_next        = drain_reg && !capture;
        wr_idx            = query_done_reg ? '0 : query_length_reg;
        q_we              = 1'b0;
        first             = (cand_len_reg == '0);
        score             = (cand_len_reg < QL_W'(MAX_LETTERS));
        h_ctrl_next       = '0;
        h_cur_next        = first ? COL_W'(cfg_reg.edit_cost)
                                  : bound_reg + COL_W'(cfg_reg.edit_cost);
        h_diag_next       = first ? '0 : bound_reg;

        if (accept && item.op == OP_QUERY)
        begin
            if (query_done_reg)
            begin
                query_done_next = 1'b0;
                query_over_next = 1'b0;
                cand_len_next   = '0;
                cand_over_next  = 1'b0;
            end
            if (wr_idx < QL_W'(MAX_LETTERS))
            begin
                q_we              = 1'b1;
                query_length_next = wr_idx + 1'b1;
            end
            else
            begin
                query_length_next = wr_idx;
                query_over_next   = 1'b1;
            end
            if (item.last)
            begin
                query_done_next = 1'b1;
            end
        end
        else if (accept && item.op == OP_CANDIDATE)
        begin
            query_done_next = 1'b1;
            if (score)
            begin
                cand_len_next = cand_len_reg + 1'b1;
                bound_next    = h_cur_next;
            end
            else
            begin
                cand_over_next = 1'b1;
            end
            prev_letter_next     = item.letter;
            h_ctrl_next.valid    = 1'b1;
            h_ctrl_next.first    = first;
            h_ctrl_next.last     = item.last;
            h_ctrl_next.score    = score;
            h_ctrl_next.too_long = query_over_reg || cand_over_next;
            h_ctrl_next.letter   = item.letter;
            h_ctrl_next.prev_letter = prev_letter_reg;
            if (item.last)
            begin
                cand_len_next  = '0;
                cand_over_next = 1'b0;
                drain_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edit_cost       <= COST_W'(100);
            cfg_reg.transpose_cost  <= COST_W'(70);
            cfg_reg.neighbour_cost  <= COST_W'(80);
            cfg_reg.sound_pair_cost <= COST_W'(65);
            query_length_reg <= '0;
            query_done_reg   <= 1'b0;
            query_over_reg   <= 1'b0;
            cand_len_reg     <= '0;
            cand_over_reg    <= 1'b0;
            prev_letter_reg  <= '0;
            bound_reg        <= '0;
            drain_reg        <= 1'b0;
            h_ctrl_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg          <= cfg_next;
            query_length_reg <= query_length_next;
            query_done_reg   <= query_done_next;
            query_over_reg   <= query_over_next;
            cand_len_reg     <= cand_len_next;
            cand_over_reg    <= cand_over_next;
            prev_letter_reg  <= prev_letter_next;
            bound_reg        <= bound_next;
            drain_reg        <= drain_next;
            h_ctrl_reg       <= h_ctrl_next;
            result_valid_reg <= capture;
        end
    end

    always_ff @(posedge clk)
    begin
        h_cur_reg  <= h_cur_next;
        h_diag_reg <= h_diag_next;
        if (capture)
        begin
            result_reg.distance <= pick_dist[DIST_W-1:0];
            result_reg.too_long <= ctrl_s[query_length_reg].too_long;
        end
    end

    assign ctrl_s[0]  = h_ctrl_reg;
    assign cur_s[0]   = h_cur_reg;
    assign diag_s[0]  = h_diag_reg;
    assign diag2_s[0] = '0;
    assign nb_s[0]    = '0;

    for (genvar k = 0; k < MAX_LETTERS; k++)
    begin : g_cell
        owd_cell #(
            .COL_W (COL_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cfg        (cfg_reg),
            .q_we       (q_we && (wr_idx == QL_W'(k))),
            .q_letter   (item.letter),
            .left_nb    (nb_s[k]),
            .left_ctrl  (ctrl_s[k]),
            .left_cur   (cur_s[k]),
            .left_diag  (diag_s[k]),
            .left_diag2 (diag2_s[k]),
            .out_nb     (nb_s[k+1]),
            .out_ctrl   (ctrl_s[k+1]),
            .out_cur    (cur_s[k+1]),
            .out_diag   (diag_s[k+1]),
            .out_diag2  (diag2_s[k+1])
        );
    end

    always_comb
    begin
        capture   = drain_reg && ctrl_s[query_length_reg].valid &&
                    ctrl_s[query_length_reg].last;
        long_dist = EXT_W'(cfg_reg.edit_cost) * EXT_W'(MAX_LETTERS);
        tap_dist  = EXT_W'(cur_s[query_length_reg]);
        pick_dist = ctrl_s[query_length_reg].too_long ? long_dist : tap_dist;
        if (pick_dist > EXT_W'(DIST_MAX))
        begin
            pick_dist = EXT_W'(DIST_MAX);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(drain_reg))
        else $error("result word without a pending final letter");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result word repeated");

    a_query_stable_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |=> $stable(query_length_reg))
        else $error("query changed while a result was pending");

    a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
        capture |=> !drain_reg && result_valid_reg)
        else $error("drain did not end at result capture");

endmodule

// ===== tb/weighted_osa_edit_distance_tb.sv =====
// Self-checking testbench for the weighted edit distance block with a scoring scoreboard.
module weighted_osa_edit_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import owd_pkg::*;

    localparam int MAX_WORD    = 24;
    localparam int SETTLE      = MAX_WORD + 8;
    localparam int PHASE_WORDS = 175;
    localparam int CYCLE_LIMIT = 300000;

    class osa_scoreboard #(int WORD_MAX = 24);
        int unsigned edit_cost  = 100;
        int unsigned swap_cost  = 70;
        int unsigned key_cost   = 80;
        int unsigned sound_cost = 65;

        int unsigned key_h [32] = '{
            13, 30, 9, 24, 33, 16, 37, 36, 18, 0, 12, 29, 14, 20, 25, 17,
            21, 10, 22, 8, 1, 40, 4, 6, 28, 32, 44, 5, 26, 41, 34, 2
        };
        int unsigned key_row [32] = '{
            1, 2, 1, 0, 1, 0, 1, 0, 2, 0, 0, 1, 2, 0, 1, 1,
            1, 2, 2, 0, 1, 0, 0, 2, 0, 0, 0, 1, 2, 1, 2, 2
        };

        bit [LETTER_W-1:0] query_text [WORD_MAX];
        int unsigned       query_len;
        bit                query_closed;
        bit                query_over;
        int unsigned       cand_len;
        bit                cand_over;
        bit [LETTER_W-1:0] prev_letter;
        int unsigned       prev_col [WORD_MAX+1];
        int unsigned       old_col [WORD_MAX+1];

        owd_out_t expected_scores [$];
        int       mismatches;
        int       results_seen;

        function void set_cost(logic [1:0] index, bit [COST_W-1:0] value);
            case (index)
                REG_EDIT:       edit_cost  = 32'(value);
                REG_TRANSPOSE:  swap_cost  = 32'(value);
                REG_NEIGHBOUR:  key_cost   = 32'(value);
                REG_SOUND_PAIR: sound_cost = 32'(value);
                default:        ;
            endcase
        endfunction

        function int pending();
            return expected_scores.size();
        endfunction

        function int unsigned lesser(int unsigned a, int unsigned b);
            return (a < b) ? a : b;
        endfunction

        function int unsigned letter_cost(bit [LETTER_W-1:0] a, bit [LETTER_W-1:0] b);
            bit [LETTER_W-1:0] lo;
            bit [LETTER_W-1:0] hi;
            int unsigned       dh;
            int unsigned       dr;
            if (a == b)
            begin
                return 0;
            end
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            case ({lo, hi})
                {5'd0, 5'd14}, {5'd5, 5'd8}, {5'd8, 5'd9}, {5'd7, 5'd17}, {5'd6, 5'd24},
                {5'd1, 5'd15}, {5'd2, 5'd20}, {5'd4, 5'd18}, {5'd3, 5'd10}:
                    return sound_cost;
                default: ;
            endcase
            dh = (key_h[a] > key_h[b]) ? key_h[a] - key_h[b] : key_h[b] - key_h[a];
            dr = (key_row[a] > key_row[b]) ? key_row[a] - key_row[b]
                                           : key_row[b] - key_row[a];
            if (dh <= 5 && dr <= 1)
            begin
                return key_cost;
            end
            return edit_cost;
        endfunction

        function void note_word(owd_in_t w);
            int unsigned fresh [WORD_MAX+1];
            int unsigned qn;
            int unsigned j;
            int unsigned v;
            int          i;
            owd_out_t    want;
            qn = (query_len < WORD_MAX) ? query_len : WORD_MAX;
            if (w.op == OP_QUERY)
            begin
                if (query_closed)
                begin
                    query_closed = 1'b0;
                    query_len    = 0;
                    query_over   = 1'b0;
                    cand_len     = 0;
                    cand_over    = 1'b0;
                end
                if (query_len < WORD_MAX)
                begin
                    query_text[query_len] = w.letter;
                    query_len++;
                end
                else
                begin
                    query_over = 1'b1;
                end
                if (w.last)
                begin
                    query_closed = 1'b1;
                end
                return;
            end
            query_closed = 1'b1;
            if (cand_len == 0 && !cand_over)
            begin
                for (i = 0; i <= qn; i++)
                begin
                    prev_col[i] = i * edit_cost;
                end
            end
            if (cand_len < WORD_MAX)
            begin
                j = cand_len + 1;
                fresh[0] = j * edit_cost;
                for (i = 1; i <= qn; i++)
                begin
                    v = lesser(prev_col[i] + edit_cost, fresh[i-1] + edit_cost);
                    v = lesser(v, prev_col[i-1] + letter_cost(query_text[i-1], w.letter));
                    if (i > 1 && j > 1 && query_text[i-1] == prev_letter &&
                        query_text[i-2] == w.letter)
                    begin
                        v = lesser(v, old_col[i-2] + swap_cost);
                    end
                    fresh[i] = v;
                end
                old_col = prev_col;
                for (i = 0; i <= qn; i++)
                begin
                    prev_col[i] = fresh[i];
                end
                cand_len = j;
            end
            else
            begin
                cand_over = 1'b1;
            end
            prev_letter = w.letter;
            if (!w.last)
            begin
                return;
            end
            if (query_over || cand_over)
            begin
                want.distance = DIST_W'(lesser(edit_cost * WORD_MAX, DIST_MAX));
                want.too_long = 1'b1;
            end
            else
            begin
                want.distance = DIST_W'(lesser(prev_col[qn], DIST_MAX));
                want.too_long = 1'b0;
            end
            cand_len  = 0;
            cand_over = 1'b0;
            expected_scores = {expected_scores, want};
        endfunction

        task report(string msg);
            if (mismatches < 40)
            begin
                $display("mismatch: %s", msg);
            end
            mismatches++;
        endtask

        task check_result(owd_out_t got);
            owd_out_t want;
            results_seen++;
            if (expected_scores.size() == 0)
            begin
                report($sformatf("unexpected word distance=%0d too_long=%0b",
                                 got.distance, got.too_long));
                return;
            end
            want = expected_scores.pop_front();
            if (got.distance !== want.distance)
            begin
                report($sformatf("distance %0d, expected %0d", got.distance, want.distance));
            end
            if (got.too_long !== want.too_long)
            begin
                report($sformatf("too_long %0b, expected %0b", got.too_long, want.too_long));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    owd_in_t              item;
    logic                 result_valid;
    owd_out_t             result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [COST_W-1:0]    cfg_data;

    osa_scoreboard #(MAX_WORD) sb;
    int                        cycles = 0;
    int                        items_sent = 0;
    int                        idle_pct = 0;
    logic [LETTER_W-1:0]       stored_query [$];

    weighted_osa_edit_distance #(.MAX_LETTERS(MAX_WORD)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            sb.check_result(result);
        end
    end

    task send_letter(logic op, logic [LETTER_W-1:0] letter, logic last);
        owd_in_t w;
        w.op     = op;
        w.letter = letter;
        w.last   = last;
        start <= 1'b1;
        item  <= w;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_word(w);
        items_sent++;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task send_text(logic op, logic [LETTER_W-1:0] text [$]);
        foreach (text[k])
        begin
            send_letter(op, text[k], k == text.size() - 1);
        end
    endtask

    task drain();
        start <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task set_costs(bit [COST_W-1:0] e, bit [COST_W-1:0] t,
                   bit [COST_W-1:0] n, bit [COST_W-1:0] s);
        logic [1:0]        regs [4];
        bit [COST_W-1:0]   vals [4];
        regs = '{REG_EDIT, REG_TRANSPOSE, REG_NEIGHBOUR, REG_SOUND_PAIR};
        vals = '{e, t, n, s};
        for (int r = 0; r < 4; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[r];
            cfg_data  <= vals[r];
            do @(posedge clk); while (cfg_ready !== 1'b1);
            sb.set_cost(regs[r], vals[r]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 65)
        begin
            return $urandom_range(1, 6);
        end
        if (r < 88)
        begin
            return $urandom_range(7, 14);
        end
        if (r < 96)
        begin
            return $urandom_range(15, 24);
        end
        return $urandom_range(25, 27);
    endfunction

    function automatic void random_text(int n, output logic [LETTER_W-1:0] text [$]);
        text = {};
        repeat (n) text = {text, 5'($urandom_range(31))};
    endfunction

    function automatic void mutate(input logic [LETTER_W-1:0] src [$],
                                   output logic [LETTER_W-1:0] text [$]);
        int                  pos;
        logic [LETTER_W-1:0] t;
        text = src;
        repeat ($urandom_range(0, 3))
        begin
            pos = $urandom_range(0, text.size() - 1);
            case ($urandom_range(3))
                0: text[pos] = 5'($urandom_range(31));
                1:
                begin
                    if (pos + 1 < text.size())
                    begin
                        t           = text[pos];
                        text[pos]   = text[pos+1];
                        text[pos+1] = t;
                    end
                end
                2: text.insert(pos, 5'($urandom_range(31)));
                default:
                begin
                    if (text.size() > 1)
                    begin
                        text.delete(pos);
                    end
                end
            endcase
        end
    endfunction

    // A query is either closed with last or left open and closed by the candidate;
    // some rounds end with a candidate that the next query cuts off.
    task run_round();
        logic [LETTER_W-1:0] text [$];
        int                  kind;
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            random_text($urandom_range(1, 5), stored_query);
            foreach (stored_query[k])
            begin
                send_letter(OP_QUERY, stored_query[k], 1'b0);
            end
        end
        else
        begin
            random_text(pick_length(), stored_query);
            send_text(OP_QUERY, stored_query);
        end
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(3) == 0)
            begin
                random_text(pick_length(), text);
            end
            else
            begin
                mutate(stored_query, text);
            end
            send_text(OP_CANDIDATE, text);
        end
        if (kind >= 10 && kind < 20)
        begin
            random_text($urandom_range(1, 3), text);
            foreach (text[k])
            begin
                send_letter(OP_CANDIDATE, text[k], 1'b0);
            end
        end
    endtask

    initial
    begin
        logic [LETTER_W-1:0] text [$];
        int                  gaps [6];
        int                  target;
        sb = new();
        gaps = '{0, 48, 20, 0, 48, 20};
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_EDIT;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Candidate against an empty query.
        send_letter(OP_CANDIDATE, 5'd31, 1'b1);
        text = '{5'd0, 5'd31, 5'd14};
        send_text(OP_QUERY, text);
        send_text(OP_CANDIDATE, text);
        text = '{5'd31, 5'd0, 5'd14};
        send_text(OP_CANDIDATE, text);
        // Sound pair, keyboard neighbour and unrelated substitution in one word.
        text = '{5'd14, 5'd23, 5'd9};
        send_text(OP_CANDIDATE, text);
        // A new query drops the candidate in progress.
        send_letter(OP_CANDIDATE, 5'd5, 1'b0);
        send_letter(OP_QUERY, 5'd7, 1'b1);
        send_letter(OP_CANDIDATE, 5'd17, 1'b1);
        // An open query is closed by the first candidate letter.
        send_letter(OP_QUERY, 5'd24, 1'b0);
        send_letter(OP_CANDIDATE, 5'd6, 1'b1);
        send_letter(OP_QUERY, 5'd3, 1'b1);
        text = '{5'd10, 5'd3};
        send_text(OP_CANDIDATE, text);

        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                drain();
                case (p)
                    1: set_costs(8'd1, 8'd255, 8'd1, 8'd255);
                    2: set_costs(8'd255, 8'd1, 8'd255, 8'd1);
                    3: set_costs(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                                 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
                    4: set_costs(8'd0, 8'd0, 8'd0, 8'd0);
                    default: set_costs(8'd255, 8'd255, 8'd255, 8'd255);
                endcase
            end
            idle_pct = gaps[p];
            target = items_sent + PHASE_WORDS;
            while (items_sent < target)
            begin
                run_round();
            end
        end
        drain();

        $display("Sent %0d letters and checked %0d distances under six cost settings,",
                 items_sent, sb.results_seen);
        $display("including overlong words and sender gaps of 0, 20 and 48 percent.");
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("[weighted_osa_edit_distance] OK");
        end
        else
        begin
            $display("[weighted_osa_edit_distance] ERROR");
        end
        $finish;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Run stopped after %0d cycles with %0d distances outstanding.",
                 cycles, sb.pending());
        $display("[weighted_osa_edit_distance] ERROR");
        $finish;
    end

endmodule
